// ===== rtl/pl0ts_pkg.sv =====
// ----------------------------------------------------------------------------
// pl0ts_pkg: shared types, codes and tables of the PL/0 token scanner
// Result layout, token kind codes, character codes, keyword table and the
// small decoders used by the scanner and the top level.
// ----------------------------------------------------------------------------
package pl0ts_pkg;

	// sizing
	localparam int NAME_CHARS    = 10;
	localparam int KEYWORD_COUNT = 18;
	localparam int LINE_BITS     = 20;

	localparam int KIND_W   = 6;
	localparam int VALUE_W  = 31;
	localparam int LINE_W   = 20;
	localparam int HEAD_W   = 64;
	localparam int TAIL_W   = 16;
	localparam int LEN_W    = 4;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = $clog2(NAME_CHARS + 1);
	localparam int IDX_W    = (NAME_CHARS > 1) ? $clog2(NAME_CHARS) : 1;
	localparam int ACC_W    = VALUE_W + 4;
	localparam int HEAD_CHARS = HEAD_W / 8;
	localparam int TAIL_CHARS = TAIL_W / 8;

	localparam int TDATA_BITS = KIND_W + VALUE_W + LINE_W + HEAD_W + TAIL_W + LEN_W;
	localparam int TDATA_W    = ((TDATA_BITS + 7) / 8) * 8;

	localparam logic [VALUE_W-1:0]   NUM_MAX  = {VALUE_W{1'b1}};
	localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
	localparam logic [LEN_W-1:0]     LEN_MAX  = {LEN_W{1'b1}};

	// result status codes
	localparam logic [STATUS_W-1:0] ST_TOKEN = 2'd0;
	localparam logic [STATUS_W-1:0] ST_END   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_DROP  = 2'd2;

	// token kinds
	localparam logic [KIND_W-1:0] KIND_INVALID    = 6'd0;
	localparam logic [KIND_W-1:0] KIND_IDENT      = 6'd1;
	localparam logic [KIND_W-1:0] KIND_NUMBER     = 6'd2;
	localparam logic [KIND_W-1:0] KIND_CONST      = 6'd3;
	localparam logic [KIND_W-1:0] KIND_VAR        = 6'd4;
	localparam logic [KIND_W-1:0] KIND_PROCEDURE  = 6'd5;
	localparam logic [KIND_W-1:0] KIND_BEGIN      = 6'd6;
	localparam logic [KIND_W-1:0] KIND_END        = 6'd7;
	localparam logic [KIND_W-1:0] KIND_IF         = 6'd8;
	localparam logic [KIND_W-1:0] KIND_WHILE      = 6'd9;
	localparam logic [KIND_W-1:0] KIND_DO         = 6'd10;
	localparam logic [KIND_W-1:0] KIND_WRITE      = 6'd11;
	localparam logic [KIND_W-1:0] KIND_READ       = 6'd12;
	localparam logic [KIND_W-1:0] KIND_CALL       = 6'd13;
	localparam logic [KIND_W-1:0] KIND_LPAREN     = 6'd14;
	localparam logic [KIND_W-1:0] KIND_RPAREN     = 6'd15;
	localparam logic [KIND_W-1:0] KIND_COMMA      = 6'd16;
	localparam logic [KIND_W-1:0] KIND_SEMI       = 6'd17;
	localparam logic [KIND_W-1:0] KIND_PERIOD     = 6'd18;
	localparam logic [KIND_W-1:0] KIND_PLUS       = 6'd19;
	localparam logic [KIND_W-1:0] KIND_MINUS      = 6'd20;
	localparam logic [KIND_W-1:0] KIND_TIMES      = 6'd21;
	localparam logic [KIND_W-1:0] KIND_SLASH      = 6'd22;
	localparam logic [KIND_W-1:0] KIND_ODD        = 6'd23;
	localparam logic [KIND_W-1:0] KIND_EQUAL      = 6'd24;
	localparam logic [KIND_W-1:0] KIND_HASH       = 6'd25;
	localparam logic [KIND_W-1:0] KIND_LESS       = 6'd26;
	localparam logic [KIND_W-1:0] KIND_LESS_EQ    = 6'd27;
	localparam logic [KIND_W-1:0] KIND_GREATER    = 6'd28;
	localparam logic [KIND_W-1:0] KIND_GREATER_EQ = 6'd29;
	localparam logic [KIND_W-1:0] KIND_ASSIGN     = 6'd30;
	localparam logic [KIND_W-1:0] KIND_ELSE       = 6'd31;
	localparam logic [KIND_W-1:0] KIND_SWITCH     = 6'd32;
	localparam logic [KIND_W-1:0] KIND_CASE       = 6'd33;
	localparam logic [KIND_W-1:0] KIND_BREAK      = 6'd34;
	localparam logic [KIND_W-1:0] KIND_DEFAULT    = 6'd35;
	localparam logic [KIND_W-1:0] KIND_ENDSWITCH  = 6'd36;
	localparam logic [KIND_W-1:0] KIND_COLON      = 6'd37;

	// character codes
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_LF      = 8'h0A;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_HASH    = 8'h23;
	localparam logic [7:0] CH_LPAREN  = 8'h28;
	localparam logic [7:0] CH_RPAREN  = 8'h29;
	localparam logic [7:0] CH_STAR    = 8'h2A;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_PERIOD  = 8'h2E;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_0       = 8'h30;
	localparam logic [7:0] CH_9       = 8'h39;
	localparam logic [7:0] CH_COLON   = 8'h3A;
	localparam logic [7:0] CH_SEMI    = 8'h3B;
	localparam logic [7:0] CH_LESS    = 8'h3C;
	localparam logic [7:0] CH_EQUAL   = 8'h3D;
	localparam logic [7:0] CH_GREATER = 8'h3E;
	localparam logic [7:0] CH_UNDER   = 8'h5F;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;

	// keyword table, text right-aligned with the first letter in the highest used byte
	localparam int KW_TABLE = 18;
	localparam int KW_MAX   = 9;
	localparam logic [8*KW_MAX-1:0] KW_TEXT [KW_TABLE] = '{
		"begin", "call", "const", "do", "end", "if", "odd", "procedure", "read",
		"var", "while", "write", "else", "switch", "case", "break", "default",
		"endswitch"
	};
	localparam int KW_LEN [KW_TABLE] = '{
		5, 4, 5, 2, 3, 2, 3, 9, 4, 3, 5, 5, 4, 6, 4, 5, 7, 9
	};
	localparam logic [KIND_W-1:0] KW_KIND [KW_TABLE] = '{
		KIND_BEGIN, KIND_CALL, KIND_CONST, KIND_DO, KIND_END, KIND_IF, KIND_ODD,
		KIND_PROCEDURE, KIND_READ, KIND_VAR, KIND_WHILE, KIND_WRITE, KIND_ELSE,
		KIND_SWITCH, KIND_CASE, KIND_BREAK, KIND_DEFAULT, KIND_ENDSWITCH
	};

	// one input item
	typedef struct packed {
		logic       mode;
		logic [7:0] char_code;
	} item_t;

	// one result item
	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [VALUE_W-1:0]  value;
		logic [LINE_W-1:0]   line;
		logic [HEAD_W-1:0]   head;
		logic [TAIL_W-1:0]   tail;
		logic [LEN_W-1:0]    len;
		logic [STATUS_W-1:0] status;
		logic                last;
	} res_t;

	// scanner answer for the item at its input
	typedef struct packed {
		logic [1:0] n_res;
		res_t       first;
		res_t       second;
	} scan_res_t;

	// single-character operator decode
	function automatic logic [KIND_W-1:0] single_kind(input logic [7:0] c);
		logic [KIND_W-1:0] k;
		unique case (c)
			CH_PLUS:   k = KIND_PLUS;
			CH_MINUS:  k = KIND_MINUS;
			CH_STAR:   k = KIND_TIMES;
			CH_SLASH:  k = KIND_SLASH;
			CH_LPAREN: k = KIND_LPAREN;
			CH_RPAREN: k = KIND_RPAREN;
			CH_EQUAL:  k = KIND_EQUAL;
			CH_COMMA:  k = KIND_COMMA;
			CH_PERIOD: k = KIND_PERIOD;
			CH_HASH:   k = KIND_HASH;
			CH_SEMI:   k = KIND_SEMI;
			CH_COLON:  k = KIND_COLON;
			default:   k = KIND_INVALID;
		endcase
		return k;
	endfunction

	// operator token of one byte, or two when the second is '='
	function automatic res_t make_op(input logic [KIND_W-1:0] kind, input logic [7:0] c0,
			input logic two, input logic [LINE_W-1:0] line);
		res_t r;
		r        = '0;
		r.kind   = kind;
		r.line   = line;
		r.head   = HEAD_W'(c0) | (two ? (HEAD_W'(CH_EQUAL) << 8) : HEAD_W'(0));
		r.len    = two ? LEN_W'(2) : LEN_W'(1);
		r.status = ST_TOKEN;
		return r;
	endfunction

	// keyword match over the kept lexeme, identifier when nothing matches
	function automatic logic [KIND_W-1:0] kw_lookup(input logic [7:0] lex [NAME_CHARS],
			input logic [COUNT_W-1:0] cnt);
		logic [KIND_W-1:0] k;
		logic              hit;
		logic [7:0]        ch;
		k = KIND_IDENT;
		for (int i = 0; i < KW_TABLE; i++) begin
			if (i < KEYWORD_COUNT) begin
				hit = (int'(cnt) == KW_LEN[i]);
				for (int j = 0; j < KW_MAX; j++) begin
					if (j < KW_LEN[i] && j < NAME_CHARS) begin
						ch = KW_TEXT[i][8*(KW_LEN[i]-1-j) +: 8];
						if (lex[j] != ch)
							hit = 1'b0;
					end
				end
				if (hit && k == KIND_IDENT)
					k = KW_KIND[i];
			end
		end
		return k;
	endfunction

endpackage

// ===== rtl/pl0ts_scan.sv =====
// ----------------------------------------------------------------------------
// pl0ts_scan: scanner state and per-byte token logic
// Holds phase, lexeme, number accumulator and line counters. For the item at
// its input it presents up to two results; state advances on step.
// ----------------------------------------------------------------------------
module pl0ts_scan (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  pl0ts_pkg::item_t     item,
	output pl0ts_pkg::scan_res_t res
);

	typedef enum logic [3:0] {
		PH_IDLE, PH_IDENT, PH_NUMBER, PH_COLON, PH_LESS, PH_GREATER,
		PH_SLASH, PH_COMMENT, PH_STAR
	} phase_t;

	phase_t                              phase_q;
	phase_t                              phase_d;
	phase_t                              fresh_phase;
	logic [7:0]                          lex_q [pl0ts_pkg::NAME_CHARS];
	logic [pl0ts_pkg::COUNT_W-1:0]       count_q;
	logic [pl0ts_pkg::VALUE_W-1:0]       acc_q;
	logic [pl0ts_pkg::LINE_BITS-1:0]     line_q;
	logic [pl0ts_pkg::LINE_BITS-1:0]     start_q;
	logic [pl0ts_pkg::LINE_BITS-1:0]     line_next;
	logic [pl0ts_pkg::ACC_W-1:0]         acc_wide;
	logic [pl0ts_pkg::VALUE_W-1:0]       acc_sat;
	logic [7:0]                          c;
	logic                                is_space;
	logic                                is_lower;
	logic                                is_digit;
	logic                                is_ident_ch;
	logic                                fresh_emit;
	logic                                fresh_starts_lex;
	logic                                do_fresh;
	logic                                keep;
	logic                                end_reset;
	logic                                room;
	logic [7:0]                          lead;
	logic [pl0ts_pkg::KIND_W-1:0]        kind_one;
	logic [pl0ts_pkg::KIND_W-1:0]        kind_two;
	logic [1:0]                          n_res;
	pl0ts_pkg::res_t                     fresh_res;
	pl0ts_pkg::res_t                     lex_res;
	pl0ts_pkg::res_t                     end_res;
	pl0ts_pkg::res_t                     r0;
	pl0ts_pkg::res_t                     r1;

	assign c = item.char_code;

	// byte classes
	assign is_space    = (c == pl0ts_pkg::CH_SPACE) || (c == pl0ts_pkg::CH_TAB) ||
		(c == pl0ts_pkg::CH_LF);
	assign is_lower    = (c >= pl0ts_pkg::CH_LOWER_A) && (c <= pl0ts_pkg::CH_LOWER_Z);
	assign is_digit    = (c >= pl0ts_pkg::CH_0) && (c <= pl0ts_pkg::CH_9);
	assign is_ident_ch = is_lower || is_digit || (c == pl0ts_pkg::CH_UNDER);

	// line counter after this byte, saturating
	assign line_next = (c == pl0ts_pkg::CH_LF && line_q != pl0ts_pkg::LINE_MAX) ?
		line_q + 1'b1 : line_q;

	// decimal accumulate with saturation
	assign acc_wide = (pl0ts_pkg::ACC_W'(acc_q) << 3) + (pl0ts_pkg::ACC_W'(acc_q) << 1) +
		pl0ts_pkg::ACC_W'(c - pl0ts_pkg::CH_0);
	assign acc_sat  = (acc_wide > pl0ts_pkg::ACC_W'(pl0ts_pkg::NUM_MAX)) ?
		pl0ts_pkg::NUM_MAX : acc_wide[pl0ts_pkg::VALUE_W-1:0];

	assign room = (count_q < pl0ts_pkg::COUNT_W'(pl0ts_pkg::NAME_CHARS));

	// scanning a byte from the idle phase
	always_comb begin
		fresh_starts_lex = is_lower || is_digit;
		fresh_emit       = 1'b0;
		if (is_lower)
			fresh_phase = PH_IDENT;
		else if (is_digit)
			fresh_phase = PH_NUMBER;
		else if (c == pl0ts_pkg::CH_COLON)
			fresh_phase = PH_COLON;
		else if (c == pl0ts_pkg::CH_LESS)
			fresh_phase = PH_LESS;
		else if (c == pl0ts_pkg::CH_GREATER)
			fresh_phase = PH_GREATER;
		else if (c == pl0ts_pkg::CH_SLASH)
			fresh_phase = PH_SLASH;
		else begin
			fresh_phase = PH_IDLE;
			fresh_emit  = !is_space;
		end
		fresh_res = pl0ts_pkg::make_op(pl0ts_pkg::single_kind(c), c, 1'b0,
			pl0ts_pkg::LINE_W'(line_next));
	end

	// pending identifier or number token
	always_comb begin
		lex_res      = '0;
		lex_res.line = pl0ts_pkg::LINE_W'(start_q);
		if (phase_q == PH_NUMBER) begin
			lex_res.kind  = pl0ts_pkg::KIND_NUMBER;
			lex_res.value = acc_q;
		end else begin
			lex_res.kind  = pl0ts_pkg::kw_lookup(lex_q, count_q);
		end
		for (int j = 0; j < pl0ts_pkg::HEAD_CHARS; j++) begin
			if (j < pl0ts_pkg::NAME_CHARS && j < int'(count_q))
				lex_res.head[8*j +: 8] = lex_q[j];
		end
		for (int j = 0; j < pl0ts_pkg::TAIL_CHARS; j++) begin
			if (j + pl0ts_pkg::HEAD_CHARS < pl0ts_pkg::NAME_CHARS &&
					j + pl0ts_pkg::HEAD_CHARS < int'(count_q))
				lex_res.tail[8*j +: 8] = lex_q[j + pl0ts_pkg::HEAD_CHARS];
		end
		lex_res.len    = (int'(count_q) > int'(pl0ts_pkg::LEN_MAX)) ? pl0ts_pkg::LEN_MAX :
			pl0ts_pkg::LEN_W'(count_q);
		lex_res.status = pl0ts_pkg::ST_TOKEN;
	end

	// end-of-text status item
	always_comb begin
		end_res      = '0;
		end_res.line = pl0ts_pkg::LINE_W'(line_q);
		end_res.status = (phase_q == PH_IDENT || phase_q == PH_NUMBER) ?
			pl0ts_pkg::ST_DROP : pl0ts_pkg::ST_END;
	end

	// pending one-byte operator codes
	always_comb begin
		unique case (phase_q)
			PH_COLON: begin
				lead     = pl0ts_pkg::CH_COLON;
				kind_one = pl0ts_pkg::KIND_COLON;
				kind_two = pl0ts_pkg::KIND_ASSIGN;
			end
			PH_LESS: begin
				lead     = pl0ts_pkg::CH_LESS;
				kind_one = pl0ts_pkg::KIND_LESS;
				kind_two = pl0ts_pkg::KIND_LESS_EQ;
			end
			PH_GREATER: begin
				lead     = pl0ts_pkg::CH_GREATER;
				kind_one = pl0ts_pkg::KIND_GREATER;
				kind_two = pl0ts_pkg::KIND_GREATER_EQ;
			end
			default: begin
				lead     = pl0ts_pkg::CH_SLASH;
				kind_one = pl0ts_pkg::KIND_SLASH;
				kind_two = pl0ts_pkg::KIND_SLASH;
			end
		endcase
	end

	// phase transitions and results
	always_comb begin
		n_res     = 2'd0;
		r0        = fresh_res;
		r1        = fresh_res;
		phase_d   = phase_q;
		do_fresh  = 1'b0;
		keep      = 1'b0;
		end_reset = 1'b0;
		if (item.mode) begin
			end_reset = 1'b1;
			phase_d   = PH_IDLE;
			unique case (phase_q) inside
				PH_COLON, PH_LESS, PH_GREATER, PH_SLASH: begin
					r0    = pl0ts_pkg::make_op(kind_one, lead, 1'b0,
						pl0ts_pkg::LINE_W'(start_q));
					r1    = end_res;
					n_res = 2'd2;
				end
				default: begin
					r0    = end_res;
					n_res = 2'd1;
				end
			endcase
		end else begin
			unique case (phase_q) inside
				PH_IDENT, PH_NUMBER: begin
					if (is_ident_ch && (phase_q == PH_IDENT || is_digit)) begin
						keep = 1'b1;
					end else begin
						r0       = lex_res;
						do_fresh = 1'b1;
						n_res    = fresh_emit ? 2'd2 : 2'd1;
					end
				end
				PH_COLON, PH_LESS, PH_GREATER: begin
					if (c == pl0ts_pkg::CH_EQUAL) begin
						r0      = pl0ts_pkg::make_op(kind_two, lead, 1'b1,
							pl0ts_pkg::LINE_W'(start_q));
						phase_d = PH_IDLE;
						n_res   = 2'd1;
					end else begin
						r0       = pl0ts_pkg::make_op(kind_one, lead, 1'b0,
							pl0ts_pkg::LINE_W'(start_q));
						do_fresh = 1'b1;
						n_res    = fresh_emit ? 2'd2 : 2'd1;
					end
				end
				PH_SLASH: begin
					if (c == pl0ts_pkg::CH_STAR) begin
						phase_d = PH_COMMENT;
					end else begin
						r0       = pl0ts_pkg::make_op(kind_one, lead, 1'b0,
							pl0ts_pkg::LINE_W'(start_q));
						do_fresh = 1'b1;
						n_res    = fresh_emit ? 2'd2 : 2'd1;
					end
				end
				PH_COMMENT: begin
					if (c == pl0ts_pkg::CH_STAR)
						phase_d = PH_STAR;
				end
				PH_STAR: begin
					if (c == pl0ts_pkg::CH_SLASH)
						phase_d = PH_IDLE;
					else if (c != pl0ts_pkg::CH_STAR)
						phase_d = PH_COMMENT;
				end
				default: begin
					do_fresh = 1'b1;
					n_res    = fresh_emit ? 2'd1 : 2'd0;
				end
			endcase
			if (do_fresh)
				phase_d = fresh_phase;
		end
		r0.last = (n_res == 2'd1);
		r1.last = 1'b1;
	end

	assign res.n_res  = n_res;
	assign res.first  = r0;
	assign res.second = r1;

	// scanner control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			count_q <= '0;
			acc_q   <= '0;
			line_q  <= pl0ts_pkg::LINE_BITS'(1);
			start_q <= pl0ts_pkg::LINE_BITS'(1);
		end else if (step) begin
			phase_q <= phase_d;
			if (end_reset) begin
				count_q <= '0;
				acc_q   <= '0;
				line_q  <= pl0ts_pkg::LINE_BITS'(1);
				start_q <= pl0ts_pkg::LINE_BITS'(1);
			end else begin
				line_q <= line_next;
				if (do_fresh) begin
					start_q <= line_next;
					acc_q   <= is_digit ? pl0ts_pkg::VALUE_W'(c - pl0ts_pkg::CH_0) : '0;
					if (fresh_starts_lex)
						count_q <= pl0ts_pkg::COUNT_W'(1);
				end else if (keep) begin
					if (phase_q == PH_NUMBER)
						acc_q <= acc_sat;
					if (room)
						count_q <= count_q + 1'b1;
				end
			end
		end
	end

	// lexeme bytes
	always_ff @(posedge clk) begin
		if (step && !item.mode) begin
			if (do_fresh && fresh_starts_lex)
				lex_q[0] <= c;
			else if (keep && room)
				lex_q[count_q[pl0ts_pkg::IDX_W-1:0]] <= c;
		end
	end

endmodule

// ===== rtl/pl0_token_scanner_core.sv =====
// Path: a byte is held in the input register and its result in the result register.
// Throughput: one byte per cycle while the master side takes results; a byte that
// causes two tokens holds the input until both have passed the single result register.
// Reset: arst_n clears the scanner to idle with line counter one, no results pending.
// ----------------------------------------------------------------------------
// pl0_token_scanner_core: streaming PL/0 lexical analyzer
// Takes source bytes or an end-of-text mark and emits tokens with their
// kind, value, line and lexeme, plus a status item at end of text.
// ----------------------------------------------------------------------------
module pl0_token_scanner_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // char_code
	input  logic                          s_tuser,   // mode
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// token_kind, number_value, line_number, name_head, name_tail, name_length
	output logic [pl0ts_pkg::TDATA_W-1:0] m_tdata,
	output logic [1:0]                    m_tuser,   // status
	output logic                          m_tlast    // last_of_run
);

	logic                 valid_s1;
	pl0ts_pkg::item_t     item_s1;
	logic                 second_q;
	logic                 m_valid_q;
	pl0ts_pkg::res_t      m_res_q;
	pl0ts_pkg::scan_res_t sr;
	logic                 out_free;
	logic                 step;
	logic                 load_out;

	// scanner on the registered item
	pl0ts_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.res    (sr)
	);

	// item retires when all its results are loaded
	assign out_free = !m_valid_q || m_tready;
	assign load_out = valid_s1 && (sr.n_res != 2'd0) && out_free;
	assign step     = valid_s1 && ((sr.n_res == 2'd0) ||
		(out_free && ((sr.n_res == 2'd1) || second_q)));
	assign s_tready = !valid_s1 || step;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid)
			item_s1 <= '{mode: s_tuser, char_code: s_tdata};
	end

	// second-result tracking and result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			second_q  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (step)
				second_q <= 1'b0;
			else if (load_out && sr.n_res == 2'd2)
				second_q <= 1'b1;
			if (load_out)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load_out)
			m_res_q <= second_q ? sr.second : sr.first;
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = pl0ts_pkg::TDATA_W'({m_res_q.len, m_res_q.tail, m_res_q.head,
		m_res_q.line, m_res_q.value, m_res_q.kind});
	assign m_tuser  = m_res_q.status;
	assign m_tlast  = m_res_q.last;

	// checks
	a_second_only_on_pair: assert property (@(posedge clk) disable iff (!arst_n)
		second_q |-> valid_s1 && sr.n_res == 2'd2)
		else $error("second result pending without a two-result item");

	a_pair_retires_on_second: assert property (@(posedge clk) disable iff (!arst_n)
		step && sr.n_res == 2'd2 |-> second_q)
		else $error("two-result item retired before its second result");

	a_first_then_second: assert property (@(posedge clk) disable iff (!arst_n)
		load_out && sr.n_res == 2'd2 && !second_q |=> second_q && valid_s1)
		else $error("first of a pair loaded without moving to the second");

	a_status_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != pl0ts_pkg::ST_TOKEN |-> m_tlast)
		else $error("end-of-text status not marked last");

endmodule

// ===== verif/tb_pl0_token_scanner_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pl0_token_scanner_core: self-checking bench for the PL/0 token scanner
// Drives a short script of source bytes and end marks, then random program text over
// the slave stream. Each token and status item on the master stream is
// compared field by field with a behavioral scanner kept in the bench or a fixed row.
// ----------------------------------------------------------------------------
module tb_pl0_token_scanner_core;

	localparam int HOLD_CYCLES  = 300;
	localparam int HOLD_START   = 300;
	localparam int STALL_LIMIT  = 5000;
	localparam int RANDOM_ITEMS = 1200;
	localparam longint unsigned LINE_TOP = (64'd1 << pl0ts_pkg::LINE_BITS) - 64'd1;

	localparam logic [7:0] CH_CR = 8'h0D;

	// bit positions of the result fields in m_tdata
	localparam int VALUE_LSB = pl0ts_pkg::KIND_W;
	localparam int LINE_LSB  = VALUE_LSB + pl0ts_pkg::VALUE_W;
	localparam int HEAD_LSB  = LINE_LSB + pl0ts_pkg::LINE_W;
	localparam int TAIL_LSB  = HEAD_LSB + pl0ts_pkg::HEAD_W;
	localparam int LEN_LSB   = TAIL_LSB + pl0ts_pkg::TAIL_W;

	typedef enum logic [3:0] {
		SCAN_IDLE, SCAN_IDENT, SCAN_NUMBER, SCAN_COLON, SCAN_LESS, SCAN_GREATER,
		SCAN_SLASH, SCAN_COMMENT, SCAN_STAR
	} scan_state_t;

	// one row of the directed script; fixed rows carry their result inline
	typedef struct {
		logic                          mode;
		logic [7:0]                    code;
		logic                          fixed;
		logic [pl0ts_pkg::KIND_W-1:0]   kind;
		logic [pl0ts_pkg::LINE_W-1:0]   line;
		logic [pl0ts_pkg::STATUS_W-1:0] status;
	} script_row_t;

	logic                          clk;
	logic                          arst_n   = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [7:0]                    s_tdata  = 8'h00;
	logic                          s_tuser  = 1'b0;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [pl0ts_pkg::TDATA_W-1:0] m_tdata;
	logic [1:0]                    m_tuser;
	logic                          m_tlast;

	pl0_token_scanner_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// keyword spellings and their kinds
	string kw_words [pl0ts_pkg::KEYWORD_COUNT] = '{
		"begin", "call", "const", "do", "end", "if", "odd", "procedure", "read",
		"var", "while", "write", "else", "switch", "case", "break", "default",
		"endswitch"
	};
	logic [pl0ts_pkg::KIND_W-1:0] kw_kinds [pl0ts_pkg::KEYWORD_COUNT] = '{
		pl0ts_pkg::KIND_BEGIN, pl0ts_pkg::KIND_CALL, pl0ts_pkg::KIND_CONST,
		pl0ts_pkg::KIND_DO, pl0ts_pkg::KIND_END, pl0ts_pkg::KIND_IF, pl0ts_pkg::KIND_ODD,
		pl0ts_pkg::KIND_PROCEDURE, pl0ts_pkg::KIND_READ, pl0ts_pkg::KIND_VAR,
		pl0ts_pkg::KIND_WHILE, pl0ts_pkg::KIND_WRITE, pl0ts_pkg::KIND_ELSE,
		pl0ts_pkg::KIND_SWITCH, pl0ts_pkg::KIND_CASE, pl0ts_pkg::KIND_BREAK,
		pl0ts_pkg::KIND_DEFAULT, pl0ts_pkg::KIND_ENDSWITCH
	};
	string op_words [17] = '{
		":=", "<=", ">=", ":", "<", ">", "+", "-", "*", "/", "(", ")", ",", ".",
		";", "=", "#"
	};
	string name_chars    = "abcdefghijklmnopqrstuvwxyz0123456789_";
	string blank_chars   = " \t\n";
	string comment_chars = "ab *\n/9";

	// directed script: extremes, operator paths, comment and end cases
	script_row_t script [27] = '{
		'{1'b0, 8'h00, 1'b1,
			pl0ts_pkg::KIND_INVALID, 20'd1, pl0ts_pkg::ST_TOKEN},
		'{1'b0, 8'hFF, 1'b1,
			pl0ts_pkg::KIND_INVALID, 20'd1, pl0ts_pkg::ST_TOKEN},
		'{1'b0, CH_CR, 1'b1,
			pl0ts_pkg::KIND_INVALID, 20'd1, pl0ts_pkg::ST_TOKEN},
		'{1'b0, pl0ts_pkg::CH_LF, 1'b0,
			pl0ts_pkg::KIND_INVALID, 20'd0, pl0ts_pkg::ST_TOKEN},
		'{1'b0, pl0ts_pkg::CH_COLON, 1'b0,
			pl0ts_pkg::KIND_INVALID, 20'd0, pl0ts_pkg::ST_TOKEN},
		'{1'b0, pl0ts_pkg::CH_EQUAL, 1'b0,
			pl0ts_pkg::KIND_INVALID, 20'd0, pl0ts_pkg::ST_TOKEN},
		'{1'b0, pl0ts_pkg::CH_TAB, 1'b0,
			pl0ts_pkg::KIND_INVALID, 20'd0, pl0ts_pkg::ST_TOKEN},
		'{1'b0, pl0ts_pkg::CH_LESS, 1'b0,
			pl0ts_pkg::KIND_INVALID, 20'd0, pl0ts_pkg::ST_TOKEN},
		'{1'b0, pl0ts_pkg::CH_GREATER, 1'b0,
			pl0ts_pkg::KIND_INVALID, 20'd0, pl0ts_pkg::ST_TOKEN},
		'{1'b0, pl0ts_pkg::CH_SLASH, 1'b0,
			pl0ts_pkg::KIND_INVALID, 20'd0, pl0ts_pkg::ST_TOKEN},
		'{1'b0, pl0ts_pkg::CH_STAR, 1'b0,
			pl0ts_pkg::KIND_INVALID, 20'd0, pl0ts_pkg::ST_TOKEN},
		'{1'b0, pl0ts_pkg::CH_STAR, 1'b0,
			pl0ts_pkg::KIND_INVALID, 20'd0, pl0ts_pkg::ST_TOKEN},
		'{1'b0, pl0ts_pkg::CH_STAR, 1'b0,
			pl0ts_pkg::KIND_INVALID, 20'd0, pl0ts_pkg::ST_TOKEN},
		'{1'b0, pl0ts_pkg::CH_SLASH, 1'b0,
			pl0ts_pkg::KIND_INVALID, 20'd0, pl0ts_pkg::ST_TOKEN},
		'{1'b0, pl0ts_pkg::CH_LOWER_Z, 1'b0,
			pl0ts_pkg::KIND_INVALID, 20'd0, pl0ts_pkg::ST_TOKEN},
		'{1'b0, pl0ts_pkg::CH_9, 1'b0,
			pl0ts_pkg::KIND_INVALID, 20'd0, pl0ts_pkg::ST_TOKEN},
		'{1'b0, pl0ts_pkg::CH_UNDER, 1'b0,
			pl0ts_pkg::KIND_INVALID, 20'd0, pl0ts_pkg::ST_TOKEN},
		'{1'b0, pl0ts_pkg::CH_LPAREN, 1'b0,
			pl0ts_pkg::KIND_INVALID, 20'd0, pl0ts_pkg::ST_TOKEN},
		'{1'b0, pl0ts_pkg::CH_0, 1'b0,
			pl0ts_pkg::KIND_INVALID, 20'd0, pl0ts_pkg::ST_TOKEN},
		'{1'b0, pl0ts_pkg::CH_SPACE, 1'b0,
			pl0ts_pkg::KIND_INVALID, 20'd0, pl0ts_pkg::ST_TOKEN},
		'{1'b0, pl0ts_pkg::CH_LESS, 1'b0,
			pl0ts_pkg::KIND_INVALID, 20'd0, pl0ts_pkg::ST_TOKEN},
		'{1'b1, 8'h00, 1'b0,
			pl0ts_pkg::KIND_INVALID, 20'd0, pl0ts_pkg::ST_TOKEN},
		'{1'b0, pl0ts_pkg::CH_LOWER_A, 1'b0,
			pl0ts_pkg::KIND_INVALID, 20'd0, pl0ts_pkg::ST_TOKEN},
		'{1'b1, 8'hFF, 1'b1,
			pl0ts_pkg::KIND_INVALID, 20'd1, pl0ts_pkg::ST_DROP},
		'{1'b0, pl0ts_pkg::CH_SLASH, 1'b0,
			pl0ts_pkg::KIND_INVALID, 20'd0, pl0ts_pkg::ST_TOKEN},
		'{1'b0, pl0ts_pkg::CH_STAR, 1'b0,
			pl0ts_pkg::KIND_INVALID, 20'd0, pl0ts_pkg::ST_TOKEN},
		'{1'b1, 8'h00, 1'b1,
			pl0ts_pkg::KIND_INVALID, 20'd1, pl0ts_pkg::ST_END}
	};

	// scanner state mirrored in the bench
	scan_state_t       scan_state = SCAN_IDLE;
	logic [7:0]        lex [pl0ts_pkg::NAME_CHARS];
	int                lex_len    = 0;
	longint unsigned   acc        = 0;
	int unsigned       line_ctr   = 1;
	int unsigned       tok_line   = 1;

	pl0ts_pkg::res_t step_out [$];
	pl0ts_pkg::res_t tokens_due [$];
	pl0ts_pkg::res_t token_want;

	int   mismatch_count = 0;
	int   quiet_cycles   = 0;
	int   items_sent     = 0;
	int   burst_left     = 0;
	logic steady         = 1'b0;
	logic hold_off       = 1'b0;

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// token built from the kept lexeme bytes
	function automatic pl0ts_pkg::res_t lexeme_token(input logic [pl0ts_pkg::KIND_W-1:0] kind,
			input logic [pl0ts_pkg::VALUE_W-1:0] value);
		pl0ts_pkg::res_t r;
		r       = '0;
		r.kind  = kind;
		r.value = value;
		r.line  = pl0ts_pkg::LINE_W'(tok_line);
		r.len   = pl0ts_pkg::LEN_W'(lex_len);
		for (int i = 0; i < lex_len; i++) begin
			if (i < pl0ts_pkg::HEAD_CHARS)
				r.head[8*i +: 8] = lex[i];
			else
				r.tail[8*(i-pl0ts_pkg::HEAD_CHARS) +: 8] = lex[i];
		end
		return r;
	endfunction

	// operator token of one byte, or two when second is nonzero
	function automatic pl0ts_pkg::res_t op_token(input logic [pl0ts_pkg::KIND_W-1:0] kind,
			input logic [7:0] c0, input logic [7:0] c1);
		pl0ts_pkg::res_t r;
		r            = '0;
		r.kind       = kind;
		r.line       = pl0ts_pkg::LINE_W'(tok_line);
		r.head[7:0]  = c0;
		r.head[15:8] = c1;
		r.len        = (c1 != 8'h00) ? pl0ts_pkg::LEN_W'(2) : pl0ts_pkg::LEN_W'(1);
		return r;
	endfunction

	function automatic logic [pl0ts_pkg::KIND_W-1:0] char_kind(input logic [7:0] c);
		case (c)
			pl0ts_pkg::CH_PLUS:   return pl0ts_pkg::KIND_PLUS;
			pl0ts_pkg::CH_MINUS:  return pl0ts_pkg::KIND_MINUS;
			pl0ts_pkg::CH_STAR:   return pl0ts_pkg::KIND_TIMES;
			pl0ts_pkg::CH_SLASH:  return pl0ts_pkg::KIND_SLASH;
			pl0ts_pkg::CH_LPAREN: return pl0ts_pkg::KIND_LPAREN;
			pl0ts_pkg::CH_RPAREN: return pl0ts_pkg::KIND_RPAREN;
			pl0ts_pkg::CH_EQUAL:  return pl0ts_pkg::KIND_EQUAL;
			pl0ts_pkg::CH_COMMA:  return pl0ts_pkg::KIND_COMMA;
			pl0ts_pkg::CH_PERIOD: return pl0ts_pkg::KIND_PERIOD;
			pl0ts_pkg::CH_HASH:   return pl0ts_pkg::KIND_HASH;
			pl0ts_pkg::CH_SEMI:   return pl0ts_pkg::KIND_SEMI;
			pl0ts_pkg::CH_COLON:  return pl0ts_pkg::KIND_COLON;
			default:              return pl0ts_pkg::KIND_INVALID;
		endcase
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= pl0ts_pkg::CH_0 && c <= pl0ts_pkg::CH_9;
	endfunction

	function automatic logic is_name_char(input logic [7:0] c);
		return (c >= pl0ts_pkg::CH_LOWER_A && c <= pl0ts_pkg::CH_LOWER_Z) || is_digit(c) ||
			c == pl0ts_pkg::CH_UNDER;
	endfunction

	// keyword kind of the kept lexeme, identifier otherwise
	function automatic logic [pl0ts_pkg::KIND_W-1:0] keyword_kind();
		string word;
		word = "";
		for (int i = 0; i < lex_len; i++)
			word = $sformatf("%s%c", word, lex[i]);
		for (int i = 0; i < pl0ts_pkg::KEYWORD_COUNT; i++)
			if (word == kw_words[i])
				return kw_kinds[i];
		return pl0ts_pkg::KIND_IDENT;
	endfunction

	task automatic keep_byte(input logic [7:0] c);
		if (lex_len < pl0ts_pkg::NAME_CHARS) begin
			lex[lex_len] = c;
			lex_len++;
		end
	endtask

	// byte seen from the idle state
	task automatic scan_fresh(input logic [7:0] c);
		tok_line = line_ctr;
		if (c == pl0ts_pkg::CH_SPACE || c == pl0ts_pkg::CH_TAB || c == pl0ts_pkg::CH_LF) begin
		end else if (c >= pl0ts_pkg::CH_LOWER_A && c <= pl0ts_pkg::CH_LOWER_Z) begin
			lex_len = 0;
			keep_byte(c);
			scan_state = SCAN_IDENT;
		end else if (is_digit(c)) begin
			lex_len = 0;
			keep_byte(c);
			acc = c - pl0ts_pkg::CH_0;
			scan_state = SCAN_NUMBER;
		end else if (c == pl0ts_pkg::CH_COLON) begin
			scan_state = SCAN_COLON;
		end else if (c == pl0ts_pkg::CH_LESS) begin
			scan_state = SCAN_LESS;
		end else if (c == pl0ts_pkg::CH_GREATER) begin
			scan_state = SCAN_GREATER;
		end else if (c == pl0ts_pkg::CH_SLASH) begin
			scan_state = SCAN_SLASH;
		end else begin
			step_out.push_back(op_token(c > 8'd127 ? pl0ts_pkg::KIND_INVALID : char_kind(c),
				c, 8'h00));
		end
	endtask

	// tokens caused by one accepted request, left in step_out
	task automatic predict_tokens(input logic mode, input logic [7:0] c);
		logic [pl0ts_pkg::STATUS_W-1:0] st;
		logic [7:0]                     lead;
		logic [pl0ts_pkg::KIND_W-1:0]   kind_two;
		logic [pl0ts_pkg::KIND_W-1:0]   kind_one;
		pl0ts_pkg::res_t                r;
		step_out.delete();
		if (mode) begin
			// end of text flushes a pending operator, then reports status
			st = pl0ts_pkg::ST_END;
			case (scan_state) inside
				SCAN_IDENT, SCAN_NUMBER: st = pl0ts_pkg::ST_DROP;
				SCAN_COLON: step_out.push_back(op_token(pl0ts_pkg::KIND_COLON,
					pl0ts_pkg::CH_COLON, 8'h00));
				SCAN_LESS: step_out.push_back(op_token(pl0ts_pkg::KIND_LESS,
					pl0ts_pkg::CH_LESS, 8'h00));
				SCAN_GREATER: step_out.push_back(op_token(pl0ts_pkg::KIND_GREATER,
					pl0ts_pkg::CH_GREATER, 8'h00));
				SCAN_SLASH: step_out.push_back(op_token(pl0ts_pkg::KIND_SLASH,
					pl0ts_pkg::CH_SLASH, 8'h00));
				default: ;
			endcase
			r        = '0;
			r.line   = pl0ts_pkg::LINE_W'(line_ctr);
			r.status = st;
			step_out.push_back(r);
			scan_state = SCAN_IDLE;
			lex_len    = 0;
			acc        = 0;
			line_ctr   = 1;
			tok_line   = 1;
		end else begin
			if (c == pl0ts_pkg::CH_LF && line_ctr < LINE_TOP)
				line_ctr++;
			case (scan_state) inside
				SCAN_IDENT: begin
					if (is_name_char(c)) begin
						keep_byte(c);
					end else begin
						step_out.push_back(lexeme_token(keyword_kind(), '0));
						scan_state = SCAN_IDLE;
						scan_fresh(c);
					end
				end
				SCAN_NUMBER: begin
					if (is_digit(c)) begin
						keep_byte(c);
						acc = acc * 10 + (c - pl0ts_pkg::CH_0);
						if (acc > pl0ts_pkg::NUM_MAX)
							acc = pl0ts_pkg::NUM_MAX;
					end else begin
						step_out.push_back(lexeme_token(pl0ts_pkg::KIND_NUMBER,
							pl0ts_pkg::VALUE_W'(acc)));
						acc = 0;
						scan_state = SCAN_IDLE;
						scan_fresh(c);
					end
				end
				SCAN_COLON, SCAN_LESS, SCAN_GREATER: begin
					case (scan_state)
						SCAN_COLON: begin
							lead     = pl0ts_pkg::CH_COLON;
							kind_two = pl0ts_pkg::KIND_ASSIGN;
							kind_one = pl0ts_pkg::KIND_COLON;
						end
						SCAN_LESS: begin
							lead     = pl0ts_pkg::CH_LESS;
							kind_two = pl0ts_pkg::KIND_LESS_EQ;
							kind_one = pl0ts_pkg::KIND_LESS;
						end
						default: begin
							lead     = pl0ts_pkg::CH_GREATER;
							kind_two = pl0ts_pkg::KIND_GREATER_EQ;
							kind_one = pl0ts_pkg::KIND_GREATER;
						end
					endcase
					scan_state = SCAN_IDLE;
					if (c == pl0ts_pkg::CH_EQUAL) begin
						step_out.push_back(op_token(kind_two, lead, pl0ts_pkg::CH_EQUAL));
					end else begin
						step_out.push_back(op_token(kind_one, lead, 8'h00));
						scan_fresh(c);
					end
				end
				SCAN_SLASH: begin
					if (c == pl0ts_pkg::CH_STAR) begin
						scan_state = SCAN_COMMENT;
					end else begin
						step_out.push_back(op_token(pl0ts_pkg::KIND_SLASH,
							pl0ts_pkg::CH_SLASH, 8'h00));
						scan_state = SCAN_IDLE;
						scan_fresh(c);
					end
				end
				SCAN_COMMENT: begin
					if (c == pl0ts_pkg::CH_STAR)
						scan_state = SCAN_STAR;
				end
				SCAN_STAR: begin
					if (c == pl0ts_pkg::CH_SLASH)
						scan_state = SCAN_IDLE;
					else if (c != pl0ts_pkg::CH_STAR)
						scan_state = SCAN_COMMENT;
				end
				default: scan_fresh(c);
			endcase
		end
		if (step_out.size() > 0)
			step_out[$].last = 1'b1;
	endtask

	// offer one request, record its tokens once accepted, then maybe pause
	task automatic send_item(input logic mode, input logic [7:0] c,
			input logic use_typed = 1'b0, input pl0ts_pkg::res_t typed = '0);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= c;
		do @(posedge clk); while (!s_tready);
		items_sent++;
		predict_tokens(mode, c);
		if (use_typed) begin
			step_out.delete();
			step_out.push_back(typed);
		end
		foreach (step_out[i])
			tokens_due.push_back(step_out[i]);
		if (burst_left > 0) begin
			burst_left--;
		end else if (!steady && !hold_off) begin
			gap = $urandom_range(1, 12);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(0, 15);
		end
	endtask

	task automatic send_text(input string text);
		for (int i = 0; i < text.len(); i++)
			send_item(1'b0, text[i]);
	endtask

	// random program: mostly well-formed tokens, some noise, then end of text
	task automatic send_program(input int budget);
		int    start;
		int    pick;
		int    n;
		logic  open_end;
		string piece;
		start    = items_sent;
		open_end = 1'b0;
		while (items_sent - start < budget && !open_end) begin
			piece = "";
			pick  = $urandom_range(0, 99);
			if (pick < 20) begin
				piece = kw_words[$urandom_range(0, pl0ts_pkg::KEYWORD_COUNT - 1)];
			end else if (pick < 25) begin
				// keyword prefix that runs on into an identifier
				piece = kw_words[$urandom_range(0, pl0ts_pkg::KEYWORD_COUNT - 1)];
				n = $urandom_range(1, 4);
				repeat (n) piece = $sformatf("%s%c", piece,
					name_chars[$urandom_range(0, name_chars.len() - 1)]);
			end else if (pick < 40) begin
				piece = $sformatf("%c", name_chars[$urandom_range(0, 25)]);
				n = $urandom_range(0, 12);
				repeat (n) piece = $sformatf("%s%c", piece,
					name_chars[$urandom_range(0, name_chars.len() - 1)]);
			end else if (pick < 52) begin
				// numbers, some long enough to saturate
				n = $urandom_range(1, 12);
				if ($urandom_range(0, 3) == 0)
					repeat (n) piece = {piece, "9"};
				else
					repeat (n) piece = $sformatf("%s%0d", piece, $urandom_range(0, 9));
			end else if (pick < 66) begin
				piece = op_words[$urandom_range(0, 16)];
			end else if (pick < 74) begin
				// comment with stray stars and slashes, rarely left open
				piece = "/*";
				n = $urandom_range(0, 8);
				repeat (n) piece = $sformatf("%s%c", piece,
					comment_chars[$urandom_range(0, comment_chars.len() - 1)]);
				if ($urandom_range(0, 9) == 0) begin
					open_end = 1'b1;
				end else begin
					n = $urandom_range(1, 3);
					repeat (n) piece = {piece, "*"};
					piece = {piece, "/"};
				end
			end else if (pick < 82) begin
				send_item(1'b0, 8'($urandom_range(0, 255)));
			end else begin
				n = $urandom_range(1, 3);
				repeat (n) piece = $sformatf("%s%c", piece, blank_chars[$urandom_range(0, 2)]);
			end
			send_text(piece);
			if (!open_end && $urandom_range(0, 1) == 0)
				send_item(1'b0, blank_chars[$urandom_range(0, 2)]);
		end
		send_item(1'b1, 8'($urandom_range(0, 255)));
	endtask

	task automatic compare_field(input string name, input logic [63:0] want,
			input logic [63:0] seen);
		if (want !== seen) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
			mismatch_count++;
		end
	endtask

	// result check against the oldest expected token
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (tokens_due.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual kind %0d status %0d",
					$time, m_tdata[pl0ts_pkg::KIND_W-1:0], m_tuser);
				mismatch_count++;
			end else begin
				token_want = tokens_due.pop_front();
				compare_field("token_kind", 64'(token_want.kind),
					64'(m_tdata[VALUE_LSB-1:0]));
				compare_field("number_value", 64'(token_want.value),
					64'(m_tdata[LINE_LSB-1:VALUE_LSB]));
				compare_field("line_number", 64'(token_want.line),
					64'(m_tdata[HEAD_LSB-1:LINE_LSB]));
				compare_field("name_head", token_want.head, m_tdata[TAIL_LSB-1:HEAD_LSB]);
				compare_field("name_tail", 64'(token_want.tail),
					64'(m_tdata[LEN_LSB-1:TAIL_LSB]));
				compare_field("name_length", 64'(token_want.len),
					64'(m_tdata[LEN_LSB+pl0ts_pkg::LEN_W-1:LEN_LSB]));
				compare_field("status", 64'(token_want.status), 64'(m_tuser));
				compare_field("last_of_run", 64'(token_want.last), 64'(m_tlast));
			end
		end
	end

	// watchdog on cycles where neither side moves a request
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb_pl0_token_scanner_core NOT OK");
			$finish;
		end
	end

	// receiver: changing stall styles, plus one long hold-off early on
	initial begin
		int   style;
		int   style_left;
		int   tick;
		logic ready;
		logic hold_done;
		style      = 0;
		style_left = 0;
		tick       = 0;
		hold_done  = 1'b0;
		forever begin
			@(posedge clk);
			if (!hold_done && items_sent >= HOLD_START) begin
				hold_done = 1'b1;
				hold_off  = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off  = 1'b0;
			end
			if (style_left == 0) begin
				style      = $urandom_range(0, 3);
				style_left = $urandom_range(20, 200);
			end
			style_left--;
			tick++;
			case (style)
				0:       ready = 1'b1;
				1:       ready = $urandom_range(0, 1);
				2:       ready = ($urandom_range(0, 7) == 0);
				default: ready = (tick % 5) < 2;
			endcase
			m_tready <= ready;
		end
	end

	// main sequence
	initial begin
		pl0ts_pkg::res_t typed;
		int              random_start;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed script
		foreach (script[i]) begin
			typed        = '0;
			typed.kind   = script[i].kind;
			typed.line   = script[i].line;
			typed.status = script[i].status;
			typed.last   = 1'b1;
			if (!script[i].mode) begin
				typed.head[7:0] = script[i].code;
				typed.len       = pl0ts_pkg::LEN_W'(1);
			end
			send_item(script[i].mode, script[i].code, script[i].fixed, typed);
		end

		// random programs
		random_start = items_sent;
		while (items_sent - random_start < RANDOM_ITEMS) begin
			send_program(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4)
				: $urandom_range(10, 60));
		end

		// a few tokens sent back to back to close the run
		steady = 1'b1;
		send_item(1'b0, pl0ts_pkg::CH_PLUS);
		send_item(1'b0, pl0ts_pkg::CH_LF);
		send_item(1'b0, pl0ts_pkg::CH_LOWER_A);
		send_item(1'b1, 8'h00);
		s_tvalid <= 1'b0;

		while (tokens_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_pl0_token_scanner_core OK");
		else
			$display("tb_pl0_token_scanner_core NOT OK");
		$finish;
	end

endmodule
